// ===== rtl/core/graph_cycle_through_vertex_assert.svh =====
// assertion macros used by the port-level checker
`ifndef GRAPH_CYCLE_THROUGH_VERTEX_ASSERT_SVH
`define GRAPH_CYCLE_THROUGH_VERTEX_ASSERT_SVH
// implication checked every clock outside reset
`define GCV_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication checked every clock outside reset
`define GCV_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== rtl/core/gcv_pkg.sv =====
// shared constants and codes of the graph cycle engine
package gcv_pkg;
    localparam int MaxVertices = 64;
    localparam int IdxW = $clog2(MaxVertices);
    localparam int CntW = $clog2(MaxVertices + 1);

    localparam logic [1:0] OP_VERTEX = 2'd0;
    localparam logic [1:0] OP_EDGE   = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_START  = 3'd1;
    localparam logic [2:0] ST_NO_END    = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NO_QUERY  = 3'd4;

    typedef logic [IdxW-1:0] t_idx;
    typedef logic [CntW-1:0] t_cnt;
    typedef logic [MaxVertices-1:0] t_row;
endpackage

// ===== rtl/core/gcv_key_store.sv =====
// vertex key memory with one registered read port and a key compare
module gcv_key_store (
    input  logic                i_clk,
    input  logic                i_we,
    input  gcv_pkg::t_idx       i_waddr,
    input  logic [31:0]         i_wdata,
    input  gcv_pkg::t_idx       i_raddr,
    input  logic [31:0]         i_key,
    output logic                o_match
);
    logic [31:0] r_mem [gcv_pkg::MaxVertices];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_match = (r_rdata == i_key);
endmodule

// ===== rtl/core/gcv_adj_store.sv =====
// adjacency row memory, one row written and one row read per cycle
module gcv_adj_store (
    input  logic                i_clk,
    input  logic                i_we,
    input  gcv_pkg::t_idx       i_waddr,
    input  gcv_pkg::t_row       i_wdata,
    input  gcv_pkg::t_idx       i_raddr,
    output gcv_pkg::t_row       o_rdata
);
    gcv_pkg::t_row r_mem [gcv_pkg::MaxVertices];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/core/gcv_stack.sv =====
// walk stack memory for the depth-first search
module gcv_stack (
    input  logic                i_clk,
    input  logic                i_we,
    input  gcv_pkg::t_idx       i_waddr,
    input  gcv_pkg::t_idx       i_wdata,
    input  gcv_pkg::t_idx       i_raddr,
    output gcv_pkg::t_idx       o_rdata
);
    gcv_pkg::t_idx r_mem [gcv_pkg::MaxVertices];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/core/graph_cycle_through_vertex.sv =====
// graph cycle engine top level: sequencer over key, adjacency and stack memories
//
//  channel | ports                                  | handshake
//  command | i_start, i_operation, i_key_a, i_key_b | taken when i_start && !o_busy
//  result  | o_done, o_status, o_cycle_found        | one-cycle strobe, no stall
//
// insert vertex: unless full, the accepting edge writes the key and clears the row.
// insert edge: two linear key scans through the key memory read port, then a
// read and write of the start row. cycle query: one scan, then a row fetch per
// popped vertex and a pick and key compare per new neighbor.
// synchronous active-low reset clears count and control; adjacency rows are
// written whole on vertex insert so need no clearing. results cannot be stalled.
module graph_cycle_through_vertex (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_operation,
    input  logic signed [31:0] i_key_a,
    input  logic signed [31:0] i_key_b,
    output logic        o_busy,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic        o_cycle_found
);
    localparam int IW = gcv_pkg::IdxW;
    localparam int CW = gcv_pkg::CntW;
    localparam int NV = gcv_pkg::MaxVertices;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCANA = 4'd1;  // address issued, compare next
    localparam logic [3:0] S_SCANB = 4'd2;
    localparam logic [3:0] S_SETE  = 4'd3;  // start row loaded from memory
    localparam logic [3:0] S_SETW  = 4'd4;
    localparam logic [3:0] S_POP   = 4'd5;
    localparam logic [3:0] S_POPW  = 4'd6;
    localparam logic [3:0] S_ROWW  = 4'd7;
    localparam logic [3:0] S_PICK  = 4'd8;
    localparam logic [3:0] S_CMP   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]          r_state, n_state;
    logic [1:0]          r_op;
    logic [31:0]         r_ka, r_kb;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_scan;     // index whose key read is in flight
    logic [IW-1:0]       r_src;
    logic [CW-1:0]       r_sp;
    gcv_pkg::t_row       r_visit, r_row;
    logic                r_found;
    logic [2:0]          r_status;
    logic                r_done;

    logic                key_we, adj_we, stk_we, match;
    logic [IW-1:0]       key_raddr, adj_addr, adj_raddr, stk_raddr;
    logic [31:0]         cmp_key;
    gcv_pkg::t_row       adj_wdata, adj_rdata;
    logic [IW-1:0]       stk_rdata;
    gcv_pkg::t_row       cand;
    logic                cand_any;
    logic [IW-1:0]       cand_idx;

    gcv_key_store u_keys (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(r_count[IW-1:0]), .i_wdata(i_key_a),
        .i_raddr(key_raddr), .i_key(cmp_key), .o_match(match)
    );
    gcv_adj_store u_adj (
        .i_clk(i_clk), .i_we(adj_we), .i_waddr(adj_addr), .i_wdata(adj_wdata),
        .i_raddr(adj_raddr), .o_rdata(adj_rdata)
    );
    gcv_stack u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(r_sp[IW-1:0]), .i_wdata(cand_idx),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    // lowest unvisited neighbor among stored vertices
    always_comb begin
        cand = r_row & ~r_visit;
        cand_any = 1'b0;
        cand_idx = '0;
        for (int i = NV - 1; i >= 0; i--) begin
            if (cand[i] && (CW'(i) < r_count)) begin
                cand_any = 1'b1;
                cand_idx = IW'(i);
            end
        end
    end

    logic start_ok;
    assign start_ok = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);

    always_comb begin
        n_state   = r_state;
        key_we    = 1'b0;
        adj_we    = 1'b0;
        stk_we    = 1'b0;
        adj_addr  = r_src;
        adj_wdata = r_row | (gcv_pkg::t_row'(1) << r_scan[IW-1:0]);
        adj_raddr = r_src;
        key_raddr = r_scan[IW-1:0];
        stk_raddr = r_sp[IW-1:0] - IW'(1);
        cmp_key   = (r_state == S_SCANB) ? r_kb : r_ka;
        if (start_ok && i_operation == gcv_pkg::OP_VERTEX && r_count != CW'(NV)) begin
            key_we    = 1'b1;
            adj_we    = 1'b1;
            adj_addr  = r_count[IW-1:0];
            adj_wdata = '0;
        end
        if (start_ok) begin
            key_raddr = '0;
        end
        case (r_state)
            S_SETW: begin
                adj_we = 1'b1;
            end
            S_PICK: begin
                key_raddr = cand_idx;
                stk_we    = cand_any && (r_sp != CW'(NV));
            end
            S_SCANA: begin
                // on a hit restart the key scan at 0 and fetch the start row
                key_raddr = match ? IW'(0) : r_scan[IW-1:0] + IW'(1);
                adj_raddr = r_scan[IW-1:0];
            end
            S_SCANB: begin
                key_raddr = r_scan[IW-1:0] + IW'(1);
            end
            S_POPW: begin
                adj_raddr = stk_rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_op     <= i_operation;
                        r_ka     <= i_key_a;
                        r_kb     <= i_key_b;
                        r_scan   <= '0;
                        r_found  <= 1'b0;
                        r_status <= gcv_pkg::ST_OK;
                        r_visit  <= '0;
                        case (i_operation)
                            gcv_pkg::OP_VERTEX: begin
                                if (r_count == CW'(NV)) begin
                                    r_status <= gcv_pkg::ST_FULL;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                end
                                r_state <= S_DONE;
                            end
                            gcv_pkg::OP_EDGE, gcv_pkg::OP_QUERY: begin
                                if (r_count == '0) begin
                                    r_status <= (i_operation == gcv_pkg::OP_EDGE) ?
                                        gcv_pkg::ST_NO_START : gcv_pkg::ST_NO_QUERY;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_SCANA;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCANA: begin
                    if (match) begin
                        r_src <= r_scan[IW-1:0];
                        r_scan <= '0;
                        if (r_op == gcv_pkg::OP_EDGE) begin
                            r_state <= S_SCANB;
                        end else begin
                            // start vertex is walked directly, stack starts empty
                            r_sp <= '0;
                            r_state <= S_ROWW;
                        end
                    end else if (r_scan + CW'(1) == r_count) begin
                        r_status <= (r_op == gcv_pkg::OP_EDGE) ?
                            gcv_pkg::ST_NO_START : gcv_pkg::ST_NO_QUERY;
                        r_state <= S_DONE;
                    end else begin
                        r_scan <= r_scan + CW'(1);
                    end
                end
                S_SCANB: begin
                    if (match) begin
                        r_state <= S_SETE;
                    end else if (r_scan + CW'(1) == r_count) begin
                        r_status <= gcv_pkg::ST_NO_END;
                        r_state <= S_DONE;
                    end else begin
                        r_scan <= r_scan + CW'(1);
                    end
                end
                S_SETE: begin
                    r_state <= S_SETW;
                end
                S_SETW: begin
                    r_state <= S_DONE;
                end
                S_POP: begin
                    if (r_sp == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_POPW;
                    end
                end
                S_POPW: begin
                    r_src <= stk_rdata;
                    r_sp  <= r_sp - CW'(1);
                    r_state <= S_ROWW;
                end
                S_ROWW: begin
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    if (cand_any) begin
                        r_visit[cand_idx] <= 1'b1;
                        if (r_sp != CW'(NV)) begin
                            r_sp <= r_sp + CW'(1);
                        end
                        r_state <= S_CMP;
                    end else begin
                        r_state <= S_POP;
                    end
                end
                S_CMP: begin
                    if (match) begin
                        r_found <= 1'b1;
                    end
                    r_state <= S_PICK;
                end
                S_DONE: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // row register: loaded from memory after a row read, cleared on a start-key hit
    logic row_load;
    assign row_load = (r_state == S_ROWW) || (r_state == S_SETE);

    always_ff @(posedge i_clk) begin
        if (row_load) begin
            r_row <= adj_rdata;
        end else if (r_state == S_SCANA && match) begin
            r_row <= '0;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_cycle_found = r_found;
endmodule

// ===== rtl/core/gcv_checker.sv =====
// port-level checker for the graph cycle engine, bound to the top level
`include "graph_cycle_through_vertex_assert.svh"
module gcv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_done,
    input logic [2:0] o_status,
    input logic       o_cycle_found
);
    `GCV_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `GCV_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, !o_busy)
    `GCV_ASSERT_IMP(a_found_ok, i_clk, i_rst_n, o_done && o_cycle_found, o_status == gcv_pkg::ST_OK)
    `GCV_ASSERT_IMP(a_status_rng, i_clk, i_rst_n, o_done, o_status <= gcv_pkg::ST_NO_QUERY)
    `GCV_ASSERT_NXT(a_done_once, i_clk, i_rst_n, o_done, !o_done)
endmodule

bind graph_cycle_through_vertex gcv_checker u_gcv_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_done(o_done), .o_status(o_status), .o_cycle_found(o_cycle_found)
);
